@@ design/ipu_pkg.sv @@
// shared types, register indexes and constants of the integer pixel upscaler
`default_nettype none

package ipu_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_SCALE_DEF = 100;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	// input function codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	// output element kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_PIXEL = 2'd1;
	localparam logic [1:0] KIND_PAD   = 2'd2;

	typedef struct packed {
		logic        func;
		logic [23:0] pixel_in;
	} in_word_t;

	typedef struct packed {
		logic        push_accepted;
		logic [1:0]  out_kind;
		logic [23:0] out_pixel;
		logic        row_end;
		logic        frame_end;
	} out_word_t;

	typedef struct packed {
		logic [6:0]  scale_factor;
		logic [12:0] source_width;
		logic [15:0] source_height;
	} cfg_t;

	// per-word outcome of the sequencer, pixel data comes from the line buffer
	typedef struct packed {
		logic       push_accepted;
		logic [1:0] out_kind;
		logic       pix_sel;
		logic       row_end;
		logic       frame_end;
	} step_res_t;

endpackage

`default_nettype wire

@@ design/integer_pixel_upscaler_unit.sv @@
// Integer nearest-neighbour upscaler for a 24-bit pixel stream.
// Input channel (in_valid/in_stall/in_word): func 0 pushes a source pixel into the
// line buffer, func 1 pulls the next output element. Every accepted word gives
// exactly one output word (out_valid/out_stall/out_word): push_accepted for a
// push, or a pixel, a zero padding byte or "nothing" for a pull, with row and
// frame end marks. Pushes are refused while a stored row is being replayed.
// Configuration (cfg_we/cfg_index/cfg_data) must be written only while idle; the
// block does not enforce it. Out-of-range values clamp to the nearest legal one
// after cfg_data is cut to the field width. A word passes the input register,
// then the result register. Throughput is one word per cycle while out_stall is
// low, set by the combinational sequencer step and the registered read port of
// the line buffer, which gives the pixel in the same cycle the result is stored.
// When out_stall is high the result register holds and the input register can
// still take one more word; in_stall rises only when both are full.
// Reset clears all counters and both pipeline valids; the registers go to
// scale 1, width 1, height 1. The line buffer is not cleared and needs no
// clearing pass: every entry is written by a push before a replay reads it.
`default_nettype none

module integer_pixel_upscaler_unit #(
	parameter int MAX_WIDTH = ipu_pkg::MAX_WIDTH_DEF,
	parameter int MAX_SCALE = ipu_pkg::MAX_SCALE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire ipu_pkg::in_word_t               in_word,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output ipu_pkg::out_word_t                   out_word,
	input  wire logic                            cfg_we,
	input  wire logic [ipu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ipu_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import ipu_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	cfg_t      cfg_q;
	logic      valid_s1;
	in_word_t  word_s1;
	logic      valid_s2;
	step_res_t res_s2;
	step_res_t res;
	logic      adv_s1;
	logic      in_take;
	logic      mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [23:0]   rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_factor  <= 7'd1;
			cfg_q.source_width  <= 13'd1;
			cfg_q.source_height <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE:  cfg_q.scale_factor  <= cfg_data[6:0];
				CFG_WIDTH:  cfg_q.source_width  <= cfg_data[12:0];
				CFG_HEIGHT: cfg_q.source_height <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the result register is free or being emptied
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= in_word;
		end
	end

	ipu_seq #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_SCALE (MAX_SCALE),
		.AW        (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.func      (word_s1.func),
		.cfg       (cfg_q),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	ipu_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_buf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (word_s1.pixel_in),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;

	always_comb begin
		out_word.push_accepted = res_s2.push_accepted;
		out_word.out_kind      = res_s2.out_kind;
		out_word.out_pixel     = res_s2.pix_sel ? rdata : 24'd0;
		out_word.row_end       = res_s2.row_end;
		out_word.frame_end     = res_s2.frame_end;
	end

	// the input side only stalls behind a full, stalled result register
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> (out_valid && out_stall))
		else $error("input stalled with result register free");

	// a frame end is always also a row end
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.frame_end) |-> (out_word.row_end && out_word.out_kind != KIND_NONE))
		else $error("frame end without row end");

	// a stored push never carries an output element
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.push_accepted) |-> (out_word.out_kind == KIND_NONE))
		else $error("push result carries an element");

endmodule

`default_nettype wire

@@ design/ipu_line_buf.sv @@
// single-port-write, single-port-read line buffer with registered read data
`default_nettype none

module ipu_line_buf #(
	parameter int DEPTH = ipu_pkg::MAX_WIDTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [23:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [23:0]   rdata
);

	logic [23:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/ipu_seq.sv @@
// replay sequencer: write column, row replay counters and padding phase
`default_nettype none

module ipu_seq #(
	parameter int MAX_WIDTH = ipu_pkg::MAX_WIDTH_DEF,
	parameter int MAX_SCALE = ipu_pkg::MAX_SCALE_DEF,
	parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              func,
	input  wire ipu_pkg::cfg_t     cfg,
	output ipu_pkg::step_res_t     res,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic                   mem_re,
	output logic [AW-1:0]          mem_raddr
);

	import ipu_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int SW = $clog2(MAX_SCALE + 1);

	logic [AW-1:0] wr_col_q, wr_col_n;
	logic          row_ready_q, row_ready_n;
	logic [AW-1:0] rd_col_q, rd_col_n;
	logic [SW-1:0] across_q, across_n;
	logic [SW-1:0] down_q, down_n;
	logic [1:0]    pad_cnt_q, pad_cnt_n;
	logic [15:0]   src_row_q, src_row_n;
	logic          in_pad_q, in_pad_n;

	logic [SW-1:0] s_eff;
	logic [WW-1:0] w_eff;
	logic [15:0]   h_eff;
	logic [31:0]   w_ext, s_ext;
	logic [3:0]    pad_prod;
	logic [1:0]    pad;

	logic [WW-1:0] wc_inc, rc_inc;
	logic [SW-1:0] ac_inc, dr_inc;
	logic [2:0]    pc_inc;
	logic [16:0]   sr_inc;
	logic          row_done;

	// out-of-range registers clamp to the nearest legal value
	always_comb begin
		if (cfg.scale_factor == '0) begin
			s_eff = SW'(1);
		end else if (32'(cfg.scale_factor) > 32'(MAX_SCALE)) begin
			s_eff = SW'(MAX_SCALE);
		end else begin
			s_eff = SW'(cfg.scale_factor);
		end
		if (cfg.source_width == '0) begin
			w_eff = WW'(1);
		end else if (32'(cfg.source_width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg.source_width);
		end
		h_eff = (cfg.source_height == '0) ? 16'd1 : cfg.source_height;
	end

	// bmp row padding is (width*scale) mod 4, only the low two bits matter
	assign w_ext    = 32'(w_eff);
	assign s_ext    = 32'(s_eff);
	assign pad_prod = {2'b00, w_ext[1:0]} * {2'b00, s_ext[1:0]};
	assign pad      = pad_prod[1:0];

	assign wc_inc = WW'(wr_col_q) + WW'(1);
	assign rc_inc = WW'(rd_col_q) + WW'(1);
	assign ac_inc = across_q + SW'(1);
	assign dr_inc = down_q + SW'(1);
	assign pc_inc = {1'b0, pad_cnt_q} + 3'd1;
	assign sr_inc = {1'b0, src_row_q} + 17'd1;

	always_comb begin
		wr_col_n    = wr_col_q;
		row_ready_n = row_ready_q;
		rd_col_n    = rd_col_q;
		across_n    = across_q;
		down_n      = down_q;
		pad_cnt_n   = pad_cnt_q;
		src_row_n   = src_row_q;
		in_pad_n    = in_pad_q;
		res         = '{push_accepted: 1'b0, out_kind: KIND_NONE, pix_sel: 1'b0,
			row_end: 1'b0, frame_end: 1'b0};
		mem_we      = 1'b0;
		mem_waddr   = wr_col_q;
		mem_re      = 1'b0;
		mem_raddr   = rd_col_q;
		row_done    = 1'b0;

		if (func == FUNC_PUSH) begin
			// pushes are refused while a row is being replayed
			if (!row_ready_q) begin
				mem_we            = step;
				res.push_accepted = 1'b1;
				if (wc_inc >= w_eff) begin
					wr_col_n    = '0;
					row_ready_n = 1'b1;
					down_n      = '0;
					rd_col_n    = '0;
					across_n    = '0;
					pad_cnt_n   = '0;
					in_pad_n    = 1'b0;
				end else begin
					wr_col_n = AW'(wc_inc);
				end
			end
		end else if (row_ready_q) begin
			if (!in_pad_q) begin
				res.out_kind = KIND_PIXEL;
				res.pix_sel  = 1'b1;
				mem_re       = step;
				if (ac_inc >= s_eff) begin
					across_n = '0;
					if (rc_inc >= w_eff) begin
						rd_col_n = '0;
						if (pad == 2'd0) begin
							row_done = 1'b1;
						end else begin
							in_pad_n  = 1'b1;
							pad_cnt_n = '0;
						end
					end else begin
						rd_col_n = AW'(rc_inc);
					end
				end else begin
					across_n = ac_inc;
				end
			end else begin
				res.out_kind = KIND_PAD;
				pad_cnt_n    = pc_inc[1:0];
				if (pc_inc >= {1'b0, pad}) begin
					row_done = 1'b1;
				end
			end

			if (row_done) begin
				res.row_end = 1'b1;
				rd_col_n    = '0;
				across_n    = '0;
				pad_cnt_n   = '0;
				in_pad_n    = 1'b0;
				if (dr_inc >= s_eff) begin
					down_n      = '0;
					row_ready_n = 1'b0;
					if (sr_inc >= {1'b0, h_eff}) begin
						src_row_n     = '0;
						res.frame_end = 1'b1;
					end else begin
						src_row_n = sr_inc[15:0];
					end
				end else begin
					down_n = dr_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_col_q    <= '0;
			row_ready_q <= 1'b0;
			rd_col_q    <= '0;
			across_q    <= '0;
			down_q      <= '0;
			pad_cnt_q   <= '0;
			src_row_q   <= '0;
			in_pad_q    <= 1'b0;
		end else if (step) begin
			wr_col_q    <= wr_col_n;
			row_ready_q <= row_ready_n;
			rd_col_q    <= rd_col_n;
			across_q    <= across_n;
			down_q      <= down_n;
			pad_cnt_q   <= pad_cnt_n;
			src_row_q   <= src_row_n;
			in_pad_q    <= in_pad_n;
		end
	end

	// padding only ever happens inside a row that is being replayed
	assert property (@(posedge clk) disable iff (!arst_n) in_pad_q |-> row_ready_q)
		else $error("padding phase outside a ready row");

	// with no row ready the replay position must sit at its start
	assert property (@(posedge clk) disable iff (!arst_n)
		!row_ready_q |-> (rd_col_q == '0 && across_q == '0 && pad_cnt_q == '0))
		else $error("replay counters not rewound while filling");

	// the buffer is never written and read by the same word
	assert property (@(posedge clk) disable iff (!arst_n) !(mem_we && mem_re))
		else $error("line buffer written and read together");

endmodule

`default_nettype wire
